// ----- src/tkd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkd_pkg - shared types and constants for the top-K scored list
// Operation and status codes, cell actions, field layout of the stream beats.
// ----------------------------------------------------------------------------
package tkd_pkg;

  // Default sizing
  localparam int DEF_LIST_DEPTH = 5;
  localparam int DEF_KEY_BITS   = 64;
  localparam int DEF_SCORE_BITS = 32;

  // Fixed field widths of the stream beats
  localparam int KEY_IN_W   = 64;
  localparam int SCORE_IN_W = 32;
  localparam int TAG_W      = 32;
  localparam int RANK_W     = 3;
  localparam int COUNT_W    = 4;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;

  // Input tdata layout
  localparam int IN_KEY_LSB   = 0;
  localparam int IN_SCORE_LSB = IN_KEY_LSB + KEY_IN_W;
  localparam int IN_TAG_LSB   = IN_SCORE_LSB + SCORE_IN_W;
  localparam int IN_DATA_W    = IN_TAG_LSB + TAG_W;

  // Output tdata layout (padded to whole bytes)
  localparam int OUT_KEY_LSB   = 0;
  localparam int OUT_SCORE_LSB = OUT_KEY_LSB + KEY_IN_W;
  localparam int OUT_TAG_LSB   = OUT_SCORE_LSB + SCORE_IN_W;
  localparam int OUT_RANK_LSB  = OUT_TAG_LSB + TAG_W;
  localparam int OUT_COUNT_LSB = OUT_RANK_LSB + RANK_W;
  localparam int OUT_USED_W    = OUT_COUNT_LSB + COUNT_W;
  localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_OFFER = 2'd0,
    OP_CLEAR = 2'd1,
    OP_DRAIN = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_INSERTED = 3'd0,
    STS_REPLACED = 3'd1,
    STS_BELOW    = 3'd2,
    STS_DUP_KEPT = 3'd3,
    STS_CLEARED  = 3'd4,
    STS_DRAINED  = 3'd5,
    STS_EMPTY    = 3'd6
  } status_t;

  // What one cell loads this cycle
  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_LOAD,
    ACT_TAKE_LEFT,
    ACT_TAKE_RIGHT
  } cell_act_t;

  // Command from the sequencer to the cell chain
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_OFFER,
    CMD_SHIFT
  } chain_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } fsm_state_t;

  // Decision on one offer, reported by the chain
  typedef struct packed {
    status_t             status;
    logic [RANK_W-1:0]   rank;
  } offer_res_t;

endpackage

// ----- src/tkd_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkd_cell - one slot of the scored list
// Holds key, score and tag; compares against the broadcast offer and loads
// the offer or a neighbor's entry as told.
// ----------------------------------------------------------------------------
module tkd_cell
  import tkd_pkg::*;
#(
  parameter int KEY_BITS = DEF_KEY_BITS,
  parameter int SCORE_W  = SCORE_IN_W
) (
  input  logic                       clk,
  input  cell_act_t                  act,
  input  logic                       occ,
  input  logic [KEY_BITS-1:0]        offer_key,
  input  logic signed [SCORE_W-1:0]  offer_score,
  input  logic [TAG_W-1:0]           offer_tag,
  input  logic [KEY_BITS-1:0]        left_key,
  input  logic signed [SCORE_W-1:0]  left_score,
  input  logic [TAG_W-1:0]           left_tag,
  input  logic [KEY_BITS-1:0]        right_key,
  input  logic signed [SCORE_W-1:0]  right_score,
  input  logic [TAG_W-1:0]           right_tag,
  output logic [KEY_BITS-1:0]        key,
  output logic signed [SCORE_W-1:0]  score,
  output logic [TAG_W-1:0]           tag,
  output logic                       hit,
  output logic                       ge
);

  // Broadcast compare against the offer
  assign hit = occ && (key == offer_key);
  assign ge  = occ && (score >= offer_score);

  // Slot contents
  always_ff @(posedge clk) begin
    case (act)
      ACT_LOAD: begin
        key   <= offer_key;
        score <= offer_score;
        tag   <= offer_tag;
      end
      ACT_TAKE_LEFT: begin
        key   <= left_key;
        score <= left_score;
        tag   <= left_tag;
      end
      ACT_TAKE_RIGHT: begin
        key   <= right_key;
        score <= right_score;
        tag   <= right_tag;
      end
      default: begin
        key   <= key;
        score <= score;
        tag   <= tag;
      end
    endcase
  end

endmodule

// ----- src/tkd_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkd_chain - row of list cells with the offer decision
// Links the cells to their neighbors, decides where an offer goes and which
// cells shift, and shifts the row toward the head on a drain.
// ----------------------------------------------------------------------------
module tkd_chain
  import tkd_pkg::*;
#(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int SCORE_W    = SCORE_IN_W,
  localparam int CW        = $clog2(LIST_DEPTH + 1)
) (
  input  logic                       clk,
  input  chain_cmd_t                 cmd,
  input  logic [CW-1:0]              count,
  input  logic [KEY_BITS-1:0]        offer_key,
  input  logic signed [SCORE_W-1:0]  offer_score,
  input  logic [TAG_W-1:0]           offer_tag,
  output offer_res_t                 res,
  output logic [KEY_BITS-1:0]        head_key,
  output logic signed [SCORE_W-1:0]  head_score,
  output logic [TAG_W-1:0]           head_tag
);

  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic [KEY_BITS-1:0]        key_q   [LIST_DEPTH];
  logic signed [SCORE_W-1:0]  score_q [LIST_DEPTH];
  logic [TAG_W-1:0]           tag_q   [LIST_DEPTH];
  cell_act_t                  act     [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]      occ;
  logic [LIST_DEPTH-1:0]      hit;
  logic [LIST_DEPTH-1:0]      ge;
  logic [LIST_DEPTH-1:0]      after_hit;
  logic [IW-1:0]              pos;
  logic [IW-1:0]              dup_idx;
  logic                       hit_any;
  logic                       keep_dup;
  logic                       good;
  logic                       full;
  logic                       apply;
  logic                       seen;
  logic                       prev_ge;

  // Cells
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]        l_key, r_key;
    logic signed [SCORE_W-1:0]  l_score, r_score;
    logic [TAG_W-1:0]           l_tag, r_tag;

    if (i == 0) begin : g_head
      assign l_key   = offer_key;
      assign l_score = offer_score;
      assign l_tag   = offer_tag;
    end else begin : g_mid_l
      assign l_key   = key_q[i-1];
      assign l_score = score_q[i-1];
      assign l_tag   = tag_q[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      assign r_key   = key_q[i];
      assign r_score = score_q[i];
      assign r_tag   = tag_q[i];
    end else begin : g_mid_r
      assign r_key   = key_q[i+1];
      assign r_score = score_q[i+1];
      assign r_tag   = tag_q[i+1];
    end

    assign occ[i] = count > CW'(i);

    tkd_cell #(
      .KEY_BITS (KEY_BITS),
      .SCORE_W  (SCORE_W)
    ) u_cell (
      .clk         (clk),
      .act         (act[i]),
      .occ         (occ[i]),
      .offer_key   (offer_key),
      .offer_score (offer_score),
      .offer_tag   (offer_tag),
      .left_key    (l_key),
      .left_score  (l_score),
      .left_tag    (l_tag),
      .right_key   (r_key),
      .right_score (r_score),
      .right_tag   (r_tag),
      .key         (key_q[i]),
      .score       (score_q[i]),
      .tag         (tag_q[i]),
      .hit         (hit[i]),
      .ge          (ge[i])
    );
  end

  assign head_key   = key_q[0];
  assign head_score = score_q[0];
  assign head_tag   = tag_q[0];

  // Offer decision: held scores >= offer form a prefix, so the first
  // cell without ge is the insertion point
  always_comb begin
    pos     = '0;
    dup_idx = '0;
    seen    = 1'b0;
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if (!ge[i]) pos = IW'(i);
      if (hit[i]) dup_idx = IW'(i);
    end
    for (int i = 0; i < LIST_DEPTH; i++) begin
      after_hit[i] = seen;
      seen         = seen | hit[i];
    end
    hit_any  = |hit;
    keep_dup = |(hit & ge);
    full     = count == CW'(LIST_DEPTH);
    // cutoff test comes before the duplicate check
    good     = !full || !ge[LIST_DEPTH-1];
    apply    = good && !keep_dup;

    if (!good) begin
      res.status = STS_BELOW;
      res.rank   = '0;
    end else if (keep_dup) begin
      res.status = STS_DUP_KEPT;
      res.rank   = RANK_W'(dup_idx);
    end else if (hit_any) begin
      res.status = STS_REPLACED;
      res.rank   = RANK_W'(pos);
    end else begin
      res.status = STS_INSERTED;
      res.rank   = RANK_W'(pos);
    end
  end

  // Per-cell action
  always_comb begin
    prev_ge = 1'b1;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      act[i] = ACT_HOLD;
      case (cmd)
        CMD_OFFER: begin
          if (apply && !ge[i]) begin
            if (prev_ge)           act[i] = ACT_LOAD;
            else if (!after_hit[i]) act[i] = ACT_TAKE_LEFT;
          end
        end
        CMD_SHIFT: act[i] = ACT_TAKE_RIGHT;
        default:   act[i] = ACT_HOLD;
      endcase
      prev_ge = ge[i];
    end
  end

endmodule

// ----- src/top_k_dedup_score_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_dedup_score_list - best-first list of scored entries, duplicates merged
// Keeps up to LIST_DEPTH entries sorted by score; offers, clear and drain.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_axis_*: tuser carries the operation (offer, clear,
//   drain), tdata the offered key, score and tag. Result beats leave on
//   m_axis_* from an output register; tuser carries the status, tlast marks
//   the final result of an operation.
//   The cell row compares an offer against every slot at once, and offer and
//   clear update the list in the accepting cycle, so a new beat can be taken
//   every cycle unless the receiver stalls; the result shows in the next cycle.
//   A drain enters the drain state in the accepting cycle, then shifts one
//   entry per cycle out of the head cell into the output register while the
//   receiver keeps up; no input is taken until the last one is registered.
//   A drain of an empty list gives one result like an offer.
//   Reset empties the list and the output register at once; slot contents
//   are left as they are and never shown while unoccupied.
//   When the receiver stalls, the result holds in the output register and
//   s_axis_tready drops until it is taken.
// ----------------------------------------------------------------------------
module top_k_dedup_score_list
  import tkd_pkg::*;
#(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int SCORE_BITS = DEF_SCORE_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // entry_key[63:0], entry_score[95:64], entry_tag[127:96]
  input  logic [IN_DATA_W-1:0]    s_axis_tdata,
  // opcode[1:0]
  input  logic [OP_W-1:0]         s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // out_key[63:0], out_score[95:64], out_tag[127:96], out_rank[130:128],
  // list_count[134:131], zero pad[135]
  output logic [OUT_DATA_W-1:0]   m_axis_tdata,
  // status[2:0]
  output logic [STATUS_W-1:0]     m_axis_tuser,
  output logic                    m_axis_tlast
);

  localparam int SW = (SCORE_BITS < SCORE_IN_W) ? SCORE_BITS : SCORE_IN_W;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  fsm_state_t              state, state_next;
  logic [CW-1:0]           count, count_next;
  logic [IW-1:0]           idx, idx_next;
  chain_cmd_t              cmd;
  offer_res_t              res;
  logic                    slot_free;
  logic                    accept;
  logic                    load_out;
  logic                    drain_last;
  op_t                     op;

  logic [KEY_BITS-1:0]     offer_key;
  logic signed [SW-1:0]    offer_score;
  logic [TAG_W-1:0]        offer_tag;
  logic signed [SCORE_IN_W-1:0] raw_score;
  logic                    sat_ok;

  logic [KEY_BITS-1:0]     head_key;
  logic signed [SW-1:0]    head_score;
  logic [TAG_W-1:0]        head_tag;

  // Output register
  logic                    out_valid;
  status_t                 out_status, out_status_next;
  logic [KEY_IN_W-1:0]     out_key, out_key_next;
  logic [SCORE_IN_W-1:0]   out_score, out_score_next;
  logic [TAG_W-1:0]        out_tag, out_tag_next;
  logic [RANK_W-1:0]       out_rank, out_rank_next;
  logic [COUNT_W-1:0]      out_count, out_count_next;
  logic                    out_last, out_last_next;

  // Input unpack; key truncated, score saturated to the stored width
  assign op        = op_t'(s_axis_tuser);
  assign offer_key = s_axis_tdata[IN_KEY_LSB +: KEY_BITS];
  assign offer_tag = s_axis_tdata[IN_TAG_LSB +: TAG_W];
  assign raw_score = s_axis_tdata[IN_SCORE_LSB +: SCORE_IN_W];
  assign sat_ok    = (&raw_score[SCORE_IN_W-1:SW-1]) || !(|raw_score[SCORE_IN_W-1:SW-1]);

  always_comb begin
    if (sat_ok) begin
      offer_score = raw_score[SW-1:0];
    end else begin
      offer_score = {raw_score[SCORE_IN_W-1], {(SW-1){~raw_score[SCORE_IN_W-1]}}};
    end
  end

  // Handshake
  assign slot_free     = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && slot_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign drain_last    = CW'(idx) == (count - CW'(1));

  tkd_chain #(
    .LIST_DEPTH (LIST_DEPTH),
    .KEY_BITS   (KEY_BITS),
    .SCORE_W    (SW)
  ) u_chain (
    .clk         (clk),
    .cmd         (cmd),
    .count       (count),
    .offer_key   (offer_key),
    .offer_score (offer_score),
    .offer_tag   (offer_tag),
    .res         (res),
    .head_key    (head_key),
    .head_score  (head_score),
    .head_tag    (head_tag)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && op == OP_DRAIN && count != '0) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (slot_free && drain_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    cmd             = CMD_NONE;
    load_out        = 1'b0;
    count_next      = count;
    idx_next        = idx;
    out_status_next = STS_CLEARED;
    out_key_next    = '0;
    out_score_next  = '0;
    out_tag_next    = '0;
    out_rank_next   = '0;
    out_count_next  = '0;
    out_last_next   = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_OFFER: begin
              cmd             = CMD_OFFER;
              load_out        = 1'b1;
              out_status_next = res.status;
              out_rank_next   = res.rank;
              if (res.status == STS_INSERTED && count != CW'(LIST_DEPTH)) begin
                count_next = count + CW'(1);
              end
              out_count_next  = COUNT_W'(count_next);
            end
            OP_CLEAR: begin
              load_out        = 1'b1;
              count_next      = '0;
              out_status_next = STS_CLEARED;
            end
            OP_DRAIN: begin
              idx_next = '0;
              if (count == '0) begin
                load_out        = 1'b1;
                out_status_next = STS_EMPTY;
              end
            end
            default: load_out = 1'b0;
          endcase
        end
      end
      S_DRAIN: begin
        if (slot_free) begin
          cmd                       = CMD_SHIFT;
          load_out                  = 1'b1;
          out_status_next           = STS_DRAINED;
          out_key_next[KEY_BITS-1:0] = head_key;
          out_score_next            = SCORE_IN_W'(head_score);
          out_tag_next              = head_tag;
          out_rank_next             = RANK_W'(idx);
          out_last_next             = drain_last;
          idx_next                  = idx + IW'(1);
          if (drain_last) count_next = '0;
        end
      end
      default: cmd = CMD_NONE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      if (load_out)           out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= out_status_next;
      out_key    <= out_key_next;
      out_score  <= out_score_next;
      out_tag    <= out_tag_next;
      out_rank   <= out_rank_next;
      out_count  <= out_count_next;
      out_last   <= out_last_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {1'b0, out_count, out_rank, out_tag, out_score, out_key};

endmodule

// ----- src/tkd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkd_checker - port-level checks for the top-K scored list
// Watches the stream ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
module tkd_checker
  import tkd_pkg::*;
#(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_DATA_W-1:0]  m_axis_tdata,
  input logic [STATUS_W-1:0]    m_axis_tuser,
  input logic                   m_axis_tlast
);

  // Reset empties the output register
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat valid right after reset");

  // Stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // Reported fill never exceeds the list depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      m_axis_tdata[OUT_COUNT_LSB +: COUNT_W] <= COUNT_W'(LIST_DEPTH))
    else $error("list count above depth");

  // Only drained entries carry key, score and tag; every other result ends its operation
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != STS_DRAINED |->
      m_axis_tlast && m_axis_tdata[OUT_RANK_LSB-1:0] == '0)
    else $error("non-drain result with data or without last");

  // No new operation is taken in the middle of a drain
  a_drain_blocks: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == STS_DRAINED && !m_axis_tlast |->
      !s_axis_tready)
    else $error("input taken during a drain");

endmodule

bind top_k_dedup_score_list tkd_checker #(.LIST_DEPTH(LIST_DEPTH)) u_tkd_checker (.*);

// ----- test/tkd_score_list_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkd_score_list_checker - scoreboard for the top-K scored list
// Watches both stream channels, keeps its own copy of the sorted list,
// predicts the result beats of every accepted input beat and compares each
// accepted result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tkd_score_list_checker
  import tkd_pkg::*;
#(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int SCORE_BITS = DEF_SCORE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_valid,
  input  logic                  s_ready,
  input  logic [IN_DATA_W-1:0]  s_data,
  input  logic [OP_W-1:0]       s_user,
  input  logic                  m_valid,
  input  logic                  m_ready,
  input  logic [OUT_DATA_W-1:0] m_data,
  input  logic [STATUS_W-1:0]   m_user,
  input  logic                  m_last,
  output int                    fail_count,
  output int                    pending,
  output int                    checked
);

  localparam logic [KEY_IN_W-1:0] KEY_MASK =
    (KEY_BITS >= 64) ? {KEY_IN_W{1'b1}} : ((64'd1 << KEY_BITS) - 64'd1);

  typedef struct {
    status_t              status;
    logic [KEY_IN_W-1:0]  key;
    logic [SCORE_IN_W-1:0] score;
    logic [TAG_W-1:0]     tag;
    logic [RANK_W-1:0]    rank;
    logic [COUNT_W-1:0]   count;
    logic                 last;
  } list_result_t;

  list_result_t        due_results[$];

  // shadow copy of the list, best first
  logic [KEY_IN_W-1:0] row_key[LIST_DEPTH];
  longint              row_score[LIST_DEPTH];
  logic [TAG_W-1:0]    row_tag[LIST_DEPTH];
  int                  row_count;

  int fails;
  int n_checked;

  // score as the block keeps it: saturated to SCORE_BITS
  function automatic longint clamp_score(logic signed [SCORE_IN_W-1:0] raw);
    longint v, hi, lo;
    v  = raw;
    hi = (longint'(1) << (SCORE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic void add_due(status_t st, logic [KEY_IN_W-1:0] k,
                                  logic [SCORE_IN_W-1:0] s, logic [TAG_W-1:0] t,
                                  int rank, int cnt, bit lst);
    list_result_t r;
    r.status = st;
    r.key    = k;
    r.score  = s;
    r.tag    = t;
    r.rank   = RANK_W'(rank);
    r.count  = COUNT_W'(cnt);
    r.last   = lst;
    due_results.insert(due_results.size(), r);
  endfunction

  // close the gap left by slot d
  function automatic void drop_slot(int d);
    for (int i = d; i + 1 < row_count; i++) begin
      row_key[i]   = row_key[i + 1];
      row_score[i] = row_score[i + 1];
      row_tag[i]   = row_tag[i + 1];
    end
    row_count--;
  endfunction

  // insert below every entry of equal or higher score; worst falls off
  function automatic int place_entry(logic [KEY_IN_W-1:0] k, longint s,
                                     logic [TAG_W-1:0] t);
    int pos, last_slot;
    pos = 0;
    while (pos < row_count && row_score[pos] >= s) pos++;
    last_slot = (row_count < LIST_DEPTH) ? row_count : LIST_DEPTH - 1;
    if (pos > last_slot) pos = last_slot;
    for (int i = last_slot; i > pos; i--) begin
      row_key[i]   = row_key[i - 1];
      row_score[i] = row_score[i - 1];
      row_tag[i]   = row_tag[i - 1];
    end
    row_key[pos]   = k;
    row_score[pos] = s;
    row_tag[pos]   = t;
    row_count      = last_slot + 1;
    return pos;
  endfunction

  // predicted results of one accepted input beat
  function automatic void predict_list_op(logic [OP_W-1:0] op,
                                          logic [IN_DATA_W-1:0] d);
    logic [KEY_IN_W-1:0] k;
    longint              s;
    logic [TAG_W-1:0]    t;
    int                  hit, r;
    bit                  room;
    k = d[IN_KEY_LSB +: KEY_IN_W] & KEY_MASK;
    s = clamp_score(d[IN_SCORE_LSB +: SCORE_IN_W]);
    t = d[IN_TAG_LSB +: TAG_W];
    case (op)
      OP_OFFER: begin
        room = (row_count < LIST_DEPTH);
        if (!room) room = (s > row_score[row_count - 1]);
        if (!room) begin
          // cutoff is checked before any key match
          add_due(STS_BELOW, '0, '0, '0, 0, row_count, 1'b1);
        end else begin
          hit = -1;
          for (int i = 0; i < row_count; i++)
            if (hit < 0 && row_key[i] == k) hit = i;
          if (hit < 0) begin
            r = place_entry(k, s, t);
            add_due(STS_INSERTED, '0, '0, '0, r, row_count, 1'b1);
          end else if (row_score[hit] >= s) begin
            add_due(STS_DUP_KEPT, '0, '0, '0, hit, row_count, 1'b1);
          end else begin
            drop_slot(hit);
            r = place_entry(k, s, t);
            add_due(STS_REPLACED, '0, '0, '0, r, row_count, 1'b1);
          end
        end
      end
      OP_CLEAR: begin
        row_count = 0;
        add_due(STS_CLEARED, '0, '0, '0, 0, 0, 1'b1);
      end
      OP_DRAIN: begin
        if (row_count == 0) begin
          add_due(STS_EMPTY, '0, '0, '0, 0, 0, 1'b1);
        end else begin
          for (int i = 0; i < row_count; i++)
            add_due(STS_DRAINED, row_key[i], SCORE_IN_W'(row_score[i]), row_tag[i],
                    i, 0, i == row_count - 1);
          row_count = 0;
        end
      end
      default: ; // unused opcode: no result, list unchanged
    endcase
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] seen);
    if (want !== seen) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
    end
  endtask

  // sample both channels at the edge where beats are taken
  always @(posedge clk) begin
    list_result_t w;
    if (rst) begin
      row_count = 0;
      due_results.delete();
      fails     = 0;
      n_checked = 0;
    end else begin
      if (m_valid && m_ready) begin
        if (due_results.size() == 0) begin
          fails++;
          $display("%0t: result beat with nothing expected, expected none, actual status %0d data %h",
                   $time, m_user, m_data);
        end else begin
          w = due_results.pop_front();
          n_checked++;
          check_field("status", 64'(w.status), 64'(m_user));
          check_field("out_key", w.key, m_data[OUT_KEY_LSB +: KEY_IN_W]);
          check_field("out_score", 64'(w.score), 64'(m_data[OUT_SCORE_LSB +: SCORE_IN_W]));
          check_field("out_tag", 64'(w.tag), 64'(m_data[OUT_TAG_LSB +: TAG_W]));
          check_field("out_rank", 64'(w.rank), 64'(m_data[OUT_RANK_LSB +: RANK_W]));
          check_field("list_count", 64'(w.count), 64'(m_data[OUT_COUNT_LSB +: COUNT_W]));
          check_field("tdata pad", 64'd0, 64'(m_data[OUT_DATA_W-1:OUT_USED_W]));
          check_field("tlast", 64'(w.last), 64'(m_last));
        end
      end
      if (s_valid && s_ready) predict_list_op(s_user, s_data);
    end
    fail_count <= fails;
    pending    <= due_results.size();
    checked    <= n_checked;
  end

endmodule

// ----- test/tb_top_k_dedup_score_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_k_dedup_score_list - testbench for the top-K scored list
// Directed offers, clears and drains on the list's corner cases, then
// random traffic over a small key pool so duplicates, ties and cutoffs are
// frequent; random idle bursts on both channels, a scoreboard alongside.
// ----------------------------------------------------------------------------
module tb_top_k_dedup_score_list;
  import tkd_pkg::*;

  localparam int                STALL_LIMIT  = 1000;
  localparam int                RANDOM_ITEMS = 430;
  localparam logic [OP_W-1:0]   OP_UNUSED    = 2'd3;
  localparam logic [SCORE_IN_W-1:0] SCORE_MIN = 32'h8000_0000;
  localparam logic [SCORE_IN_W-1:0] SCORE_MAX = 32'h7FFF_FFFF;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_data   = '0;
  logic [OP_W-1:0]       in_op     = '0;
  logic                  out_ready = 1'b0;
  logic                  calm      = 1'b0;

  logic                  in_ready;
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_last;

  int fail_count, pending, checked;
  int rx_hold   = 0;
  int idle_run  = 0;
  int n_offer   = 0;
  int n_clear   = 0;
  int n_drain   = 0;
  int n_unused  = 0;

  logic [KEY_IN_W-1:0] key_pool[10];

  top_k_dedup_score_list u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (in_ready),
    .s_axis_tdata  (in_data),
    .s_axis_tuser  (in_op),
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_data),
    .m_axis_tuser  (out_status),
    .m_axis_tlast  (out_last)
  );

  tkd_score_list_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (in_valid),
    .s_ready    (in_ready),
    .s_data     (in_data),
    .s_user     (in_op),
    .m_valid    (out_valid),
    .m_ready    (out_ready),
    .m_data     (out_data),
    .m_user     (out_status),
    .m_last     (out_last),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // receiver: random stall bursts
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold   <= rx_hold - 1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      out_ready <= 1'b0;
      rx_hold   <= $urandom_range(0, 16);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles where neither channel moves a beat
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run <= 0;
      else idle_run <= idle_run + 1;
      if (idle_run >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // one input beat, with an optional idle burst ahead of it
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [KEY_IN_W-1:0] k,
                           input logic [SCORE_IN_W-1:0] s, input logic [TAG_W-1:0] t);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_data  <= {t, s, k};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (op)
      OP_OFFER: n_offer++;
      OP_CLEAR: n_clear++;
      OP_DRAIN: n_drain++;
      default:  n_unused++;
    endcase
  endtask

  // hold the sender back until every predicted result has arrived
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [SCORE_IN_W-1:0] pick_score();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 1) ? SCORE_MAX : SCORE_MIN;
      3:       return $urandom_range(0, 1) ? SCORE_MAX - $urandom_range(0, 3)
                                           : SCORE_MIN + $urandom_range(0, 3);
      default: return SCORE_IN_W'(int'($urandom_range(0, 12)) - 6);
    endcase
  endfunction

  function automatic logic [KEY_IN_W-1:0] pick_key();
    if ($urandom_range(0, 19) == 0) key_pool[$urandom_range(0, 9)] = {$urandom, $urandom};
    if ($urandom_range(0, 6) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(0, 9)];
  endfunction

  initial begin
    int pick;
    int n;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 10; i++) key_pool[i] = {$urandom, $urandom};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list, extremes, ties, cutoff, duplicates, full drain
    send_beat(OP_DRAIN, '0, '0, '0);
    send_beat(OP_CLEAR, '0, '0, '0);
    send_beat(OP_OFFER, '0, SCORE_MIN, '0);
    send_beat(OP_OFFER, '1, SCORE_MAX, '1);
    send_beat(OP_OFFER, 64'd5, SCORE_MIN, 32'd1);       // tie ranks below old
    send_beat(OP_OFFER, '0, SCORE_MIN, 32'hAAAA_5555);  // duplicate, equal score
    send_beat(OP_OFFER, 64'd7, 32'd0, 32'd2);
    send_beat(OP_OFFER, 64'd9, 32'd0, 32'd3);           // list now full
    send_beat(OP_OFFER, 64'd11, SCORE_MIN, 32'd4);      // tie with worst: refused
    send_beat(OP_OFFER, 64'd5, SCORE_MIN, 32'd5);       // held key, still below cutoff
    send_beat(OP_OFFER, 64'd5, 32'd10, 32'd6);          // duplicate with better score
    send_beat(OP_OFFER, 64'd7, -32'sd5, 32'd7);         // duplicate not better
    send_beat(OP_OFFER, 64'd3, 32'd1, 32'd8);           // worst entry falls off
    send_beat(OP_UNUSED, {$urandom, $urandom}, $urandom, $urandom);
    send_beat(OP_DRAIN, '0, '0, '0);
    send_beat(OP_DRAIN, '0, '0, '0);
    send_beat(OP_OFFER, 64'd1, 32'd3, 32'hFFFF_0000);
    send_beat(OP_CLEAR, '1, '1, '1);
    send_beat(OP_OFFER, 64'h8000_0000_0000_0001, 32'd4, 32'h0000_FFFF);
    send_beat(OP_DRAIN, '1, '1, '1);
    wait_results_done();

    // random traffic, mostly offers over a small key pool
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n == RANDOM_ITEMS - 60) calm <= 1'b1;
      if (n % 120 == 119 && n_offer % 3 == 0) wait_results_done();
      pick = $urandom_range(0, 59);
      if (pick < 2) begin
        send_beat(OP_UNUSED, {$urandom, $urandom}, $urandom, $urandom);
      end else begin
        n++;
        if (pick < 4)       send_beat(OP_CLEAR, {$urandom, $urandom}, $urandom, $urandom);
        else if (pick < 10) send_beat(OP_DRAIN, {$urandom, $urandom}, $urandom, $urandom);
        else                send_beat(OP_OFFER, pick_key(), pick_score(), $urandom);
      end
    end

    // let the last results drain out
    wait_results_done();
    repeat (20) @(posedge clk);

    $display("Covered %0d offers, %0d clears, %0d drains and %0d unused-opcode beats,",
             n_offer, n_clear, n_drain, n_unused);
    $display("with %0d result beats compared against the predicted list.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
